### rtl/fwht_pkg.sv
// ----------------------------------------------------------------------------
// fwht_pkg
// Shared types and constants for the Walsh-Hadamard transform block.
// ----------------------------------------------------------------------------
package fwht_pkg;

    // default configuration of the top level
    localparam int MAX_POINTS_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed result field widths
    localparam int COEF_W   = 22;
    localparam int IDX_W    = 6;
    localparam int ENERGY_W = 43;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BF_RD,
        S_BF_WA,
        S_BF_WB,
        S_EM_RD,
        S_EM_SCALE,
        S_EM_SQ,
        S_EM_ACC
    } t_state;

    // controls from the sequencer to the output scaling unit
    typedef struct packed {
        logic clear;
        logic scale;
        logic square;
        logic accum;
    } t_emit_ctl;

endpackage

### rtl/fwht_ram.sv
// ----------------------------------------------------------------------------
// fwht_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module fwht_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/fwht_emit.sv
// ----------------------------------------------------------------------------
// fwht_emit
// Output unit: inverse scaling with rounding, saturation to the coefficient
// width, squaring and saturating energy accumulation.
// ----------------------------------------------------------------------------
module fwht_emit #(
    parameter int WORK_W = 22,
    parameter int LG_W   = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fwht_pkg::t_emit_ctl                 i_ctl,
    input  logic signed [WORK_W-1:0]            i_data,
    input  logic [LG_W-1:0]                     i_lg,
    input  logic                                i_inverse,
    output logic signed [fwht_pkg::COEF_W-1:0]  o_coef,
    output logic [fwht_pkg::ENERGY_W-1:0]       o_energy_sum
);

    localparam int EXT_W = WORK_W + 1;
    localparam int SAT_W = (EXT_W > fwht_pkg::COEF_W) ? EXT_W : fwht_pkg::COEF_W;
    localparam logic signed [SAT_W-1:0] C_MAX = SAT_W'((2 ** (fwht_pkg::COEF_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] C_MIN = -SAT_W'(2 ** (fwht_pkg::COEF_W - 1));

    logic signed [fwht_pkg::COEF_W-1:0]     r_coef;
    logic [fwht_pkg::ENERGY_W-1:0]          r_sq;
    logic [fwht_pkg::ENERGY_W-1:0]          r_energy;

    logic signed [EXT_W-1:0]                v_ext;
    logic signed [EXT_W-1:0]                v_rnd;
    logic signed [EXT_W-1:0]                v_shift;
    logic signed [SAT_W-1:0]                v_wide;
    logic signed [fwht_pkg::COEF_W-1:0]     v_sat;
    logic signed [2*fwht_pkg::COEF_W-1:0]   prod;
    logic [fwht_pkg::ENERGY_W:0]            sum;

    // divide by n with round half up in inverse mode
    always_comb begin
        v_ext = EXT_W'(i_data);
        if (i_inverse && (i_lg != '0)) begin
            v_rnd   = v_ext + (EXT_W'(1) << (i_lg - LG_W'(1)));
            v_shift = v_rnd >>> i_lg;
        end else begin
            v_rnd   = v_ext;
            v_shift = v_ext;
        end
        v_wide = SAT_W'(v_shift);
        if (v_wide > C_MAX) begin
            v_sat = fwht_pkg::COEF_W'(C_MAX);
        end else if (v_wide < C_MIN) begin
            v_sat = fwht_pkg::COEF_W'(C_MIN);
        end else begin
            v_sat = fwht_pkg::COEF_W'(v_wide);
        end
    end

    // square and saturating sum
    assign prod = r_coef * r_coef;
    assign sum  = {1'b0, r_energy} + {1'b0, r_sq};
    assign o_energy_sum = sum[fwht_pkg::ENERGY_W] ? '1 : sum[fwht_pkg::ENERGY_W-1:0];
    assign o_coef = r_coef;

    // coefficient, square and energy registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
        end else if (i_ctl.clear) begin
            r_energy <= '0;
        end else if (i_ctl.accum) begin
            r_energy <= o_energy_sum;
        end
        if (i_ctl.scale) begin
            r_coef <= v_sat;
        end
        if (i_ctl.square) begin
            r_sq <= prod[fwht_pkg::ENERGY_W-1:0];
        end
    end

endmodule

### rtl/fast_walsh_hadamard_transform.sv
// ----------------------------------------------------------------------------
// fast_walsh_hadamard_transform
// Loads signed samples, runs an in-place Walsh-Hadamard transform on one
// shared add/subtract butterfly, and emits the coefficients in index order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one sample per item, one cycle
//   each while idle. An item with i_final_sample set closes the set (count C)
//   and starts the run on N = next power of two >= C; samples past
//   MAX_POINTS are dropped and reported on o_overflowed.
//   While a run is in progress o_in_stall stays high.
//   Output channel (o_out_valid / i_out_stall): N items, coef_index 0..N-1,
//   o_end_of_run and o_energy on the last one.
//   Butterflies: (N/2)*log2(N) of them, each a read, a write of the sum and
//   a write of the difference (BF_RD, BF_WA, BF_WB) through the two-read,
//   one-write work RAM. Emit: per coefficient a RAM read, scale, square and
//   accumulate step, paced by the output register.
//   A stalled receiver holds the output register and pauses the emit
//   sequence; the next set can be loaded once the last item is registered.
//   Reset clears the sample count, drop flag, inverse mode and the output
//   valid; the work RAM needs no clearing since unwritten padding entries
//   are read as zero in the first butterfly stage.
// ----------------------------------------------------------------------------
module fast_walsh_hadamard_transform #(
    parameter int MAX_POINTS  = fwht_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = fwht_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_final_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [fwht_pkg::COEF_W-1:0]  o_coefficient,
    output logic [fwht_pkg::IDX_W-1:0]          o_coef_index,
    output logic                                o_end_of_run,
    output logic [fwht_pkg::ENERGY_W-1:0]       o_energy,
    output logic                                o_overflowed
);

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int DEPTH  = 1 << AW;
    localparam int CNT_W  = AW + 1;
    localparam int LG_W   = $clog2(AW + 1);
    localparam int WORK_W = SAMPLE_BITS + AW;

    fwht_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]           r_cnt;
    logic                       r_drop;
    logic                       r_inverse;
    logic                       r_run_ovf;
    logic [LG_W-1:0]            r_lg;
    logic [LG_W-1:0]            r_stage;
    logic [AW-1:0]              r_b;
    logic [AW-1:0]              r_i;
    logic signed [WORK_W-1:0]   r_diff;

    logic                                r_out_valid;
    logic signed [fwht_pkg::COEF_W-1:0]  r_out_coef;
    logic [fwht_pkg::IDX_W-1:0]          r_out_idx;
    logic                                r_out_end;
    logic [fwht_pkg::ENERGY_W-1:0]       r_out_energy;
    logic                                r_out_ovf;

    logic                       in_acc;
    logic                       full;
    logic [CNT_W-1:0]           cnt_new;
    logic [CNT_W-1:0]           cnt_m1;
    logic [LG_W-1:0]            lg_new;
    logic [AW:0]                n_full;
    logic [AW-1:0]              last_b;
    logic [AW-1:0]              last_i;
    logic [AW-1:0]              h_mask;
    logic [AW-1:0]              bf_h;
    logic [AW-1:0]              bf_j;
    logic [AW-1:0]              bf_k;
    logic                       bf_last_b;
    logic                       bf_last_stage;
    logic                       em_last;
    logic                       out_free;
    logic                       out_load;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [WORK_W-1:0]          ram_wdata;
    logic [AW-1:0]              ram_raddr_a;
    logic [AW-1:0]              ram_raddr_b;
    logic [WORK_W-1:0]          ram_rdata_a;
    logic [WORK_W-1:0]          ram_rdata_b;
    logic signed [WORK_W-1:0]   bf_a;
    logic signed [WORK_W-1:0]   bf_bv;
    logic signed [WORK_W-1:0]   bf_sum;
    logic signed [WORK_W-1:0]   bf_dif;

    fwht_pkg::t_emit_ctl                 emit_ctl;
    logic signed [fwht_pkg::COEF_W-1:0]  emit_coef;
    logic [fwht_pkg::ENERGY_W-1:0]       emit_energy;

    // input handshake and load bookkeeping
    assign in_acc  = i_in_valid && !o_in_stall;
    assign full    = (r_cnt == CNT_W'(MAX_POINTS));
    assign cnt_new = full ? r_cnt : r_cnt + CNT_W'(1);
    assign cnt_m1  = cnt_new - CNT_W'(1);

    // log2 of the padded size: one past the top set bit of count - 1
    always_comb begin
        lg_new = '0;
        for (int p = 0; p < CNT_W; p++) begin
            if (cnt_m1[p]) begin
                lg_new = LG_W'(p + 1);
            end
        end
    end

    // butterfly pair addresses: insert a zero at bit stage of the counter
    assign n_full        = (AW + 1)'(1) << r_lg;
    assign last_b        = AW'((n_full >> 1) - (AW + 1)'(1));
    assign last_i        = AW'(n_full - (AW + 1)'(1));
    assign bf_h          = AW'((AW + 1)'(1) << r_stage);
    assign h_mask        = bf_h - AW'(1);
    assign bf_j          = AW'({(r_b & ~h_mask), 1'b0}) | (r_b & h_mask);
    assign bf_k          = bf_j | bf_h;
    assign bf_last_b     = (r_b == last_b);
    assign bf_last_stage = (r_stage == (r_lg - LG_W'(1)));
    assign em_last       = (r_i == last_i);

    // shared butterfly; padding entries read as zero in the first stage
    always_comb begin
        bf_a  = ((r_stage == '0) && (CNT_W'(bf_j) >= r_cnt)) ? '0 : ram_rdata_a;
        bf_bv = ((r_stage == '0) && (CNT_W'(bf_k) >= r_cnt)) ? '0 : ram_rdata_b;
        bf_sum = bf_a + bf_bv;
        bf_dif = bf_a - bf_bv;
    end

    // output register is free when empty or being taken
    assign out_free = !r_out_valid || !i_out_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwht_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath controls
    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = bf_j;
        ram_wdata   = bf_sum;
        ram_raddr_a = bf_j;
        ram_raddr_b = bf_k;
        emit_ctl    = '0;
        out_load    = 1'b0;
        case (r_state)
            fwht_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                ram_waddr  = r_cnt[AW-1:0];
                ram_wdata  = WORK_W'(i_sample);
                if (in_acc) begin
                    ram_we = !full;
                    if (i_final_sample) begin
                        emit_ctl.clear = 1'b1;
                        n_state = (lg_new == '0) ? fwht_pkg::S_EM_RD : fwht_pkg::S_BF_RD;
                    end
                end
            end
            fwht_pkg::S_BF_RD: begin
                n_state = fwht_pkg::S_BF_WA;
            end
            fwht_pkg::S_BF_WA: begin
                ram_we    = 1'b1;
                ram_waddr = bf_j;
                ram_wdata = bf_sum;
                n_state   = fwht_pkg::S_BF_WB;
            end
            fwht_pkg::S_BF_WB: begin
                ram_we    = 1'b1;
                ram_waddr = bf_k;
                ram_wdata = r_diff;
                if (bf_last_b && bf_last_stage) begin
                    n_state = fwht_pkg::S_EM_RD;
                end else begin
                    n_state = fwht_pkg::S_BF_RD;
                end
            end
            fwht_pkg::S_EM_RD: begin
                ram_raddr_a = r_i;
                n_state     = fwht_pkg::S_EM_SCALE;
            end
            fwht_pkg::S_EM_SCALE: begin
                emit_ctl.scale = 1'b1;
                n_state        = fwht_pkg::S_EM_SQ;
            end
            fwht_pkg::S_EM_SQ: begin
                emit_ctl.square = 1'b1;
                n_state         = fwht_pkg::S_EM_ACC;
            end
            fwht_pkg::S_EM_ACC: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    emit_ctl.accum = 1'b1;
                    n_state = em_last ? fwht_pkg::S_IDLE : fwht_pkg::S_EM_RD;
                end
            end
            default: begin
                n_state = fwht_pkg::S_IDLE;
            end
        endcase
    end

    // counters, flags and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_inverse <= 1'b0;
            r_stage   <= '0;
            r_b       <= '0;
            r_i       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_inverse <= i_cfg_wdata;
            end
            if (r_state == fwht_pkg::S_IDLE && in_acc) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (i_final_sample) begin
                    r_stage <= '0;
                    r_b     <= '0;
                    r_i     <= '0;
                end
            end
            if (r_state == fwht_pkg::S_BF_WB) begin
                if (bf_last_b) begin
                    r_b     <= '0;
                    r_stage <= r_stage + LG_W'(1);
                end else begin
                    r_b <= r_b + AW'(1);
                end
            end
            if (out_load) begin
                r_i <= r_i + AW'(1);
                if (em_last) begin
                    r_cnt  <= '0;
                    r_drop <= 1'b0;
                end
            end
        end
    end

    // run parameters and butterfly difference
    always_ff @(posedge i_clk) begin
        if (r_state == fwht_pkg::S_IDLE && in_acc && i_final_sample) begin
            r_lg      <= lg_new;
            r_run_ovf <= r_drop || full;
        end
        if (r_state == fwht_pkg::S_BF_WA) begin
            r_diff <= bf_dif;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_coef   <= emit_coef;
            r_out_idx    <= fwht_pkg::IDX_W'(r_i);
            r_out_end    <= em_last;
            r_out_energy <= em_last ? emit_energy : '0;
            r_out_ovf    <= r_run_ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out_coef;
    assign o_coef_index  = r_out_idx;
    assign o_end_of_run  = r_out_end;
    assign o_energy      = r_out_energy;
    assign o_overflowed  = r_out_ovf;

    // work store
    fwht_ram #(
        .WIDTH (WORK_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // scaling and energy unit
    fwht_emit #(
        .WORK_W (WORK_W),
        .LG_W   (LG_W)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (emit_ctl),
        .i_data       (ram_rdata_a),
        .i_lg         (r_lg),
        .i_inverse    (r_inverse),
        .o_coef       (emit_coef),
        .o_energy_sum (emit_energy)
    );

    // sample count never passes capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("sample count beyond capacity");

    // butterflies only run on stages that exist and stay inside n
    a_bf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwht_pkg::S_BF_RD) |-> ((r_stage < r_lg) && ((AW + 1)'(bf_k) < n_full)))
        else $error("butterfly address out of range");

    // energy only reported on the last item of a run
    a_energy_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_end_of_run) |-> (o_energy == '0))
        else $error("energy on a non-final item");

    // the last coefficient ends the run and empties the sample store
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && em_last) |=> ((r_state == fwht_pkg::S_IDLE) && (r_cnt == '0) && !r_drop))
        else $error("run did not close after the last coefficient");

endmodule

### sim/fast_walsh_hadamard_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_walsh_hadamard_transform_tb
// Sends sample sets into the transform block and checks every coefficient
// item against an in-bench integer Walsh-Hadamard model. The run covers both
// modes, padding, a full store with dropped samples, random idling on both
// channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module fast_walsh_hadamard_transform_tb;

    localparam int NPTS          = fwht_pkg::MAX_POINTS_DEF;
    localparam int SAMPLE_W      = fwht_pkg::SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 1500;

    localparam logic MODE_FORWARD = 1'b0;
    localparam logic MODE_INVERSE = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint COEF_HI = (64'sd1 <<< (fwht_pkg::COEF_W - 1)) - 1;
    localparam longint COEF_LO = -(64'sd1 <<< (fwht_pkg::COEF_W - 1));
    localparam longint unsigned ENERGY_SAT = (64'd1 << fwht_pkg::ENERGY_W) - 1;

    typedef struct packed {
        logic signed [fwht_pkg::COEF_W-1:0] coef;
        logic [fwht_pkg::IDX_W-1:0]         idx;
        logic                               last;
        logic [fwht_pkg::ENERGY_W-1:0]      energy;
        logic                               ovf;
    } t_coef_item;

    // block ports
    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_cfg_we       = 1'b0;
    logic                                i_cfg_wdata    = 1'b0;
    logic                                i_in_valid     = 1'b0;
    logic                                o_in_stall;
    logic signed [SAMPLE_W-1:0]          i_sample       = '0;
    logic                                i_final_sample = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall    = 1'b0;
    logic signed [fwht_pkg::COEF_W-1:0]  o_coefficient;
    logic [fwht_pkg::IDX_W-1:0]          o_coef_index;
    logic                                o_end_of_run;
    logic [fwht_pkg::ENERGY_W-1:0]       o_energy;
    logic                                o_overflowed;

    // transform model state
    longint     sample_buf[NPTS];
    int         held_count = 0;
    logic       drop_seen  = 1'b0;
    logic       inv_mode   = MODE_FORWARD;
    t_coef_item expected_coefs[$];

    // run control
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    fast_walsh_hadamard_transform dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_final_sample (i_final_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coefficient  (o_coefficient),
        .o_coef_index   (o_coef_index),
        .o_end_of_run   (o_end_of_run),
        .o_energy       (o_energy),
        .o_overflowed   (o_overflowed)
    );

    always #2 i_clk = ~i_clk;

    // store one accepted sample; on the final one run the butterflies
    // and queue the coefficient items the block must produce
    function automatic void take_sample(input logic signed [SAMPLE_W-1:0] s,
                                        input logic fin);
        int n, lg, h, i, j;
        longint a, b, v;
        longint unsigned acc;
        t_coef_item r;
        if (held_count < NPTS) begin
            sample_buf[held_count] = s;
            held_count++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!fin) return;

        // pad up to the next power of two
        n  = 1;
        lg = 0;
        while (n < held_count) begin
            n = n * 2;
            lg++;
        end
        for (i = held_count; i < n; i++) sample_buf[i] = 0;

        // in-place radix-2 butterflies
        for (h = 1; h < n; h = h * 2) begin
            for (i = 0; i < n; i += 2 * h) begin
                for (j = i; j < i + h; j++) begin
                    a = sample_buf[j];
                    b = sample_buf[j + h];
                    sample_buf[j]     = a + b;
                    sample_buf[j + h] = a - b;
                end
            end
        end

        // scale, saturate and accumulate energy in index order
        acc = 0;
        for (i = 0; i < n; i++) begin
            v = sample_buf[i];
            if (inv_mode == MODE_INVERSE && lg > 0)
                v = (v + (64'sd1 <<< (lg - 1))) >>> lg;
            if (v > COEF_HI) v = COEF_HI;
            else if (v < COEF_LO) v = COEF_LO;
            acc += v * v;
            if (acc > ENERGY_SAT) acc = ENERGY_SAT;
            r.coef   = v[fwht_pkg::COEF_W-1:0];
            r.idx    = i[fwht_pkg::IDX_W-1:0];
            r.last   = (i == n - 1);
            r.energy = (i == n - 1) ? acc[fwht_pkg::ENERGY_W-1:0] : '0;
            r.ovf    = drop_seen;
            expected_coefs.push_back(r);
        end
        held_count = 0;
        drop_seen  = 1'b0;
    endfunction

    // offer one item, with random idle cycles ahead of it
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_sample       <= s;
        i_final_sample <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        take_sample(s, fin);
    endtask

    // stop offering and wait until every coefficient has come out
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_coefs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_inverse_mode(input logic m);
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        inv_mode = m;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // mostly small sets, a few large ones and a few past capacity
    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 8);
        if (r < 85) return $urandom_range(9, 32);
        if (r < 95) return $urandom_range(33, NPTS);
        return $urandom_range(NPTS + 1, NPTS + 4);
    endfunction

    task automatic push_set(input int size);
        int k;
        for (k = 0; k < size; k++) push_sample(pick_sample(), k == size - 1);
    endtask

    // extremes, single samples and padding, unscaled
    task automatic test_directed_forward();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_inverse_mode(MODE_FORWARD);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd3, 1'b0);
        push_sample(16'sd7, 1'b1);
    endtask

    // rounding ties, single sample with no shift, padding to eight
    task automatic test_directed_inverse();
        write_inverse_mode(MODE_INVERSE);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd2, 1'b0);
        push_sample(16'sd3, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
    endtask

    // full store, the final sample itself is dropped
    task automatic test_store_overflow();
        write_inverse_mode(MODE_FORWARD);
        push_set(NPTS + 1);
    endtask

    task automatic test_random_sets(input int n_items, input int idle_pct,
                                    input int stall, input logic m);
        int sent, size;
        write_inverse_mode(m);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        sent = 0;
        while (sent < n_items) begin
            size = pick_set_size();
            push_set(size);
            sent += size;
        end
    endtask

    // long receiver hold-off while sets keep coming, then sets with full pauses
    task automatic test_backpressure();
        write_inverse_mode(MODE_FORWARD);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        push_set(12);
        push_set(12);
        push_set(12);
        wait_for_drain();
        push_set(20);
        wait_for_drain();
        push_set(8);
    endtask

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // compare each coefficient item with the oldest expectation
    always @(posedge i_clk) begin : check_coef
        t_coef_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_coefs.size() == 0) begin
                $error("unexpected coefficient item, coef_index %0d", o_coef_index);
                fail_count++;
            end else begin
                want = expected_coefs.pop_front();
                if (o_coefficient !== want.coef) begin
                    $error("coefficient: expected %0d, got %0d", want.coef, o_coefficient);
                    fail_count++;
                end
                if (o_coef_index !== want.idx) begin
                    $error("coef_index: expected %0d, got %0d", want.idx, o_coef_index);
                    fail_count++;
                end
                if (o_end_of_run !== want.last) begin
                    $error("end_of_run: expected %0d, got %0d", want.last, o_end_of_run);
                    fail_count++;
                end
                if (o_energy !== want.energy) begin
                    $error("energy: expected %0d, got %0d", want.energy, o_energy);
                    fail_count++;
                end
                if (o_overflowed !== want.ovf) begin
                    $error("overflowed: expected %0d, got %0d", want.ovf, o_overflowed);
                    fail_count++;
                end
            end
        end
    end

    // run time limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fast_walsh_hadamard_transform test failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_forward();
        test_directed_inverse();
        test_store_overflow();
        test_random_sets(60, 0, 0, MODE_INVERSE);
        test_random_sets(60, 56, 0, MODE_FORWARD);
        test_random_sets(60, 0, 56, MODE_INVERSE);
        test_random_sets(60, 37, 37, MODE_FORWARD);
        test_backpressure();

        wait_for_drain();
        repeat (30) @(posedge i_clk);
        if (expected_coefs.size() != 0) begin
            $error("%0d coefficient items never arrived", expected_coefs.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("fast_walsh_hadamard_transform test passed");
        end else begin
            $display("fast_walsh_hadamard_transform test failed");
        end
        $finish;
    end

endmodule
